// ----- rtl/sitda_pkg.sv -----
// sitda_pkg: shared types and constants for the signed integer to decimal ASCII block.
// Holds the controller/datapath command and status structs and the character codes.
// No dependencies.
`default_nettype none

package sitda_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned NDIGITS  = 10;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned BCD_W    = NDIGITS * DIGIT_W;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned BITCNT_W = 5;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

	typedef logic [DIGIT_W-1:0] digit_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;       // capture sign and magnitude, clear BCD
		logic       shift;      // one double-dabble step
		logic       out_load;   // load output character register
		logic       out_minus;  // character is the minus sign
		logic       out_last;   // character closes the run
		digit_idx_t dig_sel;    // BCD digit to emit
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       neg;        // captured value was negative
		digit_idx_t lead;       // index of most significant nonzero digit (0 for zero)
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/sitda_datapath.sv -----
// sitda_datapath: magnitude capture, double-dabble binary to BCD, and output character register.
// Depends on sitda_pkg; driven by sitda_ctrl through cmd_t, reports through status_t.
`default_nettype none

module sitda_datapath
	import sitda_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire cmd_t                      cmd,
	output status_t                        status,
	output logic             [CHAR_W-1:0]  char_out,
	output logic                           last
);

	logic [VALUE_W-1:0]                 bin_q;
	logic [NDIGITS-1:0][DIGIT_W-1:0]    bcd_q;
	logic                               neg_q;
	logic [NDIGITS-1:0][DIGIT_W-1:0]    bcd_adj;
	logic [VALUE_W-1:0]                 mag;
	digit_idx_t                         lead;

	// unsigned magnitude; the most negative value maps to 2^31
	assign mag = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);

	// add 3 to each digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NDIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
	end

	always_comb begin
		lead = '0;
		for (int i = 1; i < NDIGITS; i++) begin
			if (bcd_q[i] != '0) begin
				lead = DIGIT_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			bcd_q <= '0;
			neg_q <= value[VALUE_W-1];
		end else if (cmd.shift) begin
			{bcd_q, bin_q} <= {bcd_adj[NDIGITS-1:0], bin_q} << 1;
		end
		if (cmd.out_load) begin
			char_out <= cmd.out_minus ? ASCII_MINUS
			                          : (ASCII_ZERO + CHAR_W'(bcd_q[cmd.dig_sel]));
			last     <= cmd.out_last;
		end
	end

	assign status.neg  = neg_q;
	assign status.lead = lead;

endmodule

`default_nettype wire

// ----- rtl/sitda_ctrl.sv -----
// sitda_ctrl: sequencing state machine for the conversion and character emission.
// Depends on sitda_pkg; commands sitda_datapath, owns both handshakes.
`default_nettype none

module sitda_ctrl
	import sitda_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_DIGIT = 3'd4;

	logic [2:0]          state_q, state_d;
	logic [BITCNT_W-1:0] cnt_q, cnt_d;
	digit_idx_t          dig_q, dig_d;
	logic                out_valid_q;
	logic                slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		dig_d         = dig_q;
		cmd           = '0;
		cmd.dig_sel   = dig_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				cnt_d     = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				dig_d   = status.lead;
				state_d = status.neg ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				if (slot_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_minus = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = (dig_q == '0);
					if (dig_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						dig_d = dig_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			dig_q   <= dig_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// signed_int_to_decimal_ascii: top level, signed 32-bit integer to decimal ASCII character run.
// Sequence: after the input transfer come 32 double-dabble steps, a step to locate the leading digit,
// and the load of the output register, which makes the first character valid.
// Pacing: each value gives 1..11 characters. A new value is taken only once the last character
// of the previous one is loaded, so the bit-serial BCD conversion and output stalls set the pace.
// Reset: arst_n clears the controller and output valid at once; data registers are not reset.
`default_nettype none

module signed_int_to_decimal_ascii
	import sitda_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input channel: one value per transfer
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [VALUE_W-1:0] value,
	// output channel: one character per transfer, last marks the end of the text
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic             [CHAR_W-1:0]  char_out,
	output logic                           last
);

	// Command and status between the sequencer and the datapath.
	cmd_t    cmd;
	status_t status;

	// Sequencer: idle -> 32 conversion steps -> leading-digit pick -> optional '-' -> digits.
	// The output register frees the input side: a new value is taken as soon as the
	// last character is loaded, even while that character still waits downstream.
	sitda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: unsigned magnitude (most negative value included), shift-and-add-3
	// BCD conversion, and the character register that drives the output payload.
	sitda_datapath u_datapath (
		.clk      (clk),
		.value    (value),
		.cmd      (cmd),
		.status   (status),
		.char_out (char_out),
		.last     (last)
	);

endmodule

`default_nettype wire

// ----- test/tb_signed_int_to_decimal_ascii.sv -----
// tb_signed_int_to_decimal_ascii: self-checking bench for the signed integer to decimal ASCII block.
// Predicts each value's character run, checks char_out/last per transfer under random gaps and stalls.
// Depends on rtl/sitda_pkg.sv and rtl/signed_int_to_decimal_ascii.sv.
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii
	import sitda_pkg::*;
();

	localparam int          CLK_HALF     = 5;
	localparam int          RESET_CYCLES = 5;
	localparam int          RANDOM_ITEMS = 460;
	localparam int          DRAIN_CYCLES = 60;   // covers the conversion and up to 11 chars
	localparam logic [31:0] DECIMAL_BASE = 32'd10;

	// receiver stall behavior, switched to a random mode when its phase runs out
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic signed [VALUE_W-1:0] value     = '0;
	logic                      out_stall = 1'b0;
	logic                      in_stall;
	logic                      out_valid;
	logic        [CHAR_W-1:0]  char_out;
	logic                      last;

	signed_int_to_decimal_ascii uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_out (char_out),
		.last     (last)
	);

	always #CLK_HALF clk = ~clk;

	// values waiting to be sent, and the text still owed by the block
	logic signed [VALUE_W-1:0] pending_values[$];
	logic        [CHAR_W-1:0]  owed_chars[$];
	bit                        owed_last[$];

	int          mismatches = 0;
	logic        in_took    = 1'b0;  // input transfer happened at the last rising edge
	int          burst_left = 1;
	int          gap_left   = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_phase_left = 0;
	int          stall_tick = 0;

	// Decimal text of one value: optional minus, then digits most significant first.
	// Magnitude is taken unsigned so the most negative value needs no special path.
	function automatic void queue_decimal_text(input logic signed [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] raw;
		logic [VALUE_W-1:0] mag;
		logic [CHAR_W-1:0]  digs[NDIGITS];
		int                 nd;
		raw = v;
		mag = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
		nd  = 0;
		do begin
			digs[nd] = ASCII_ZERO + CHAR_W'(mag % DECIMAL_BASE);
			nd++;
			mag = mag / DECIMAL_BASE;
		end while (mag != 0 && nd < NDIGITS);
		if (raw[VALUE_W-1]) begin
			owed_chars.push_back(ASCII_MINUS);
			owed_last.push_back(1'b0);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			owed_chars.push_back(digs[i]);
			owed_last.push_back(i == 0);
		end
	endfunction

	// Input side: sampled at the rising edge, prediction made on each transfer.
	always @(posedge clk) begin
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			queue_decimal_text(value);
	end

	// Driver: a new payload only after the previous one transferred (or none was up).
	// Bursts of random length are separated by random gaps; some bursts are long
	// with no gap so the block also sees back-to-back transfers.
	always @(negedge clk) begin : drive_values
		logic                      nxt_valid;
		logic signed [VALUE_W-1:0] nxt_value;
		nxt_valid = in_valid;
		nxt_value = value;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (!in_valid || in_took) begin
			if (gap_left > 0) begin
				nxt_valid = 1'b0;
				gap_left--;
			end else if (pending_values.size() > 0) begin
				nxt_valid = 1'b1;
				nxt_value = pending_values.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
				end
			end else begin
				nxt_valid = 1'b0;
			end
		end
		in_valid <= nxt_valid;
		value    <= nxt_value;
	end

	// Receiver stall pattern: mode changes at random, independent of the sender.
	always @(negedge clk) begin : drive_stall
		logic nxt_stall;
		if (stall_phase_left <= 0) begin
			stall_mode       = stall_mode_t'($urandom_range(0, 3));
			stall_phase_left = $urandom_range(50, 400);
		end
		stall_phase_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE:     nxt_stall = 1'b0;
			STALL_LIGHT:    nxt_stall = ($urandom_range(0, 9) < 3);
			STALL_HEAVY:    nxt_stall = ($urandom_range(0, 9) < 8);
			STALL_PERIODIC: nxt_stall = (stall_tick % 3 != 0);
			default:        nxt_stall = 1'b0;
		endcase
		out_stall <= nxt_stall;
	end

	// Output side: each character transfer is checked against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (owed_chars.size() == 0) begin
				$error("unexpected character transfer: char_out %0d last %0d", char_out, last);
				mismatches++;
			end else begin
				if (char_out !== owed_chars[0]) begin
					$error("char_out mismatch: expected %0d, actual %0d", owed_chars[0], char_out);
					mismatches++;
				end
				if (last !== owed_last[0]) begin
					$error("last mismatch: expected %0d, actual %0d", owed_last[0], last);
					mismatches++;
				end
				void'(owed_chars.pop_front());
				void'(owed_last.pop_front());
			end
		end
	end

	// Random value: fully random, or shaped toward a chosen digit count, the ends of the range, or small numbers.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		longint unsigned lo;
		longint unsigned hi;
		logic [VALUE_W-1:0] mag;
		int                 ndig;
		case ($urandom_range(0, 4))
			0: return $urandom();
			1, 2: begin
				ndig = $urandom_range(1, NDIGITS);
				lo   = 1;
				for (int i = 1; i < ndig; i++)
					lo = lo * 10;
				hi = (ndig == NDIGITS) ? 64'd2147483647 : lo * 10 - 1;
				if (ndig == 1)
					lo = 0;
				mag = VALUE_W'(lo + ({$urandom(), $urandom()} % (hi - lo + 1)));
				return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
			end
			3: return $signed(32'($urandom_range(0, 40))) - 20;
			default: begin
				// near the most positive and most negative values
				if ($urandom_range(0, 1))
					return 32'sh7FFF_FFFF - $signed(32'($urandom_range(0, 15)));
				else
					return 32'sh8000_0000 + $signed(32'($urandom_range(0, 15)));
			end
		endcase
	endfunction

	initial begin
		// directed: zero, single digits, digit-count boundaries, both extremes,
		// the most negative value, and alternating bit patterns
		pending_values.push_back(0);
		pending_values.push_back(1);
		pending_values.push_back(-1);
		pending_values.push_back(9);
		pending_values.push_back(-9);
		pending_values.push_back(10);
		pending_values.push_back(-10);
		pending_values.push_back(99);
		pending_values.push_back(100);
		pending_values.push_back(999999999);
		pending_values.push_back(-999999999);
		pending_values.push_back(1000000000);
		pending_values.push_back(-1000000000);
		pending_values.push_back(1234567890);
		pending_values.push_back(-1234567890);
		pending_values.push_back(32'sh7FFF_FFFF);
		pending_values.push_back(32'sh8000_0000);
		pending_values.push_back(32'sh8000_0001);
		pending_values.push_back(32'sh5555_5555);
		pending_values.push_back(32'shAAAA_AAAA);
		pending_values.push_back(32'sh0000_FFFF);
		pending_values.push_back(32'shFFFF_0000);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending_values.push_back(pick_value());

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// in_valid and the pending queue only move at the falling edge, so at a
		// rising edge they show whether a transfer can still come
		@(posedge clk);
		while (pending_values.size() != 0 || in_valid || owed_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// hang guard: fails the run if it is still going at the time limit below
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
